### sv/fqws_pkg.sv
package fqws_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 5;
  localparam int DATA_W = 32;
  localparam int OP_W = 3;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL = 2'd3;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic [CNT_W-1:0]         position;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         entry_count;
  } fqws_res_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } fqws_mem_req_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + IDX_W'(1);
    end
    return nxt;
  endfunction

endpackage

### sv/fqws_ram.sv
module fqws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/fqws_seq.sv
module fqws_seq
  import fqws_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [OP_W-1:0]          req_op,
  input  logic signed [DATA_W-1:0] req_value,
  output fqws_mem_req_t            mem_req,
  input  logic [DATA_W-1:0]        mem_rdata,
  output logic                     res_valid,
  output fqws_res_t                res,
  input  logic                     res_take
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  fqws_res_t         res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    val_r <= val_nxt;
    idx_r <= idx_nxt;
    iss_r <= iss_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    iss_nxt   = iss_r;
    res_nxt   = res_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = tail_r;
    mem_req.wdata = val_r;
    mem_req.raddr = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt    = req_op;
          val_nxt   = req_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt.value_out = '0;
        res_nxt.position  = '0;
        res_nxt.status    = ST_OK;
        mem_req.raddr     = head_r;
        state_nxt         = S_DONE;
        unique case (op_r)
          OP_ENQUEUE: begin
            if (count_r == DEPTH_CNT) begin
              res_nxt.status = ST_FULL;
            end else begin
              mem_req.we = 1'b1;
              tail_nxt   = ring_next(tail_r);
              count_nxt  = count_r + CNT_W'(1);
            end
          end
          OP_DEQUEUE, OP_PEEK: begin
            if (count_r == '0) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              state_nxt = S_READ;
            end
          end
          OP_SEARCH: begin
            if (count_r == '0) begin
              res_nxt.status = ST_NOT_FOUND;
            end else begin
              idx_nxt   = ring_next(head_r);
              iss_nxt   = CNT_W'(1);
              state_nxt = S_SCAN;
            end
          end
          OP_CLEAR: begin
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = '0;
          end
          default: begin
          end
        endcase
        res_nxt.entry_count = count_nxt;
      end
      S_READ: begin
        res_nxt.value_out = mem_rdata;
        if (op_r == OP_DEQUEUE) begin
          head_nxt  = ring_next(head_r);
          count_nxt = count_r - CNT_W'(1);
        end
        res_nxt.entry_count = count_nxt;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (mem_rdata == val_r) begin
          res_nxt.position = iss_r;
          state_nxt        = S_DONE;
        end else if (iss_r == count_r) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = ring_next(idx_r);
          iss_nxt = iss_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

### sv/fifo_queue_with_search.sv
// First-in first-out queue of signed 32-bit words with a linear search.
// Each request on the in_ channel carries an operation in in_tuser
// (enqueue, dequeue, peek, search, clear) and a value in in_tdata.
// Exactly one result leaves on the out_ channel for every request: the
// dequeued or peeked value, the 1-based match position of a search, the
// entry count after the operation in out_tdata, and a status in out_tuser.
// Enqueue, clear, unused operation codes and requests that find the queue
// empty or full go from acceptance through the execute and done states;
// dequeue and peek add a read state, since the storage RAM has a
// registered read. A search reads one entry per cycle from the head through
// the single RAM read port and one comparator; it inspects at most DEPTH.
// One request is processed at a time; in_tready is high only while the
// sequencer is idle. A finished result sits in an output register, so the
// next request may be accepted while the receiver stalls; a result that
// meets a still-full output register waits in the sequencer. Reset empties
// the queue and drops any pending result; stored words are not cleared.
module fifo_queue_with_search
  import fqws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // [31:0] value
  input  logic [2:0]  in_tuser,  // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // [31:0] value_out, [36:32] position,
                                 // [41:37] entry_count, [47:42] zero
  output logic [1:0]  out_tuser  // [1:0] status
);

  fqws_mem_req_t    mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic             res_valid;
  logic             res_take;
  fqws_res_t        res;
  logic             out_valid_r, out_valid_nxt;
  fqws_res_t        out_r, out_nxt;

  fqws_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .raddr(mem_req.raddr),
    .rdata(mem_rdata)
  );

  fqws_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req_op   (in_tuser),
    .req_value(in_tdata),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.entry_count, out_r.position, out_r.value_out};
  assign out_tuser  = out_r.status;

endmodule

### tb/sv/queue_result_checker.sv
`timescale 1ns / 100ps

module queue_result_checker
  import fqws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          mismatches,
  output int          outstanding
);

  logic [DATA_W-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]  head_idx;
  logic [IDX_W-1:0]  tail_idx;
  logic [CNT_W-1:0]  held;
  fqws_res_t         pending_results [$];
  fqws_res_t         want;
  int                results_seen;

  initial begin
    mismatches = 0;
    outstanding = 0;
    results_seen = 0;
    head_idx = '0;
    tail_idx = '0;
    held = '0;
  end

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) begin
      $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
    end
  endtask

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
    return IDX_W'((int'(idx) + 1) % DEPTH);
  endfunction

  function automatic fqws_res_t apply_queue_op(input logic [OP_W-1:0] op,
                                               input logic [DATA_W-1:0] val);
    fqws_res_t res;
    logic [IDX_W-1:0] idx;
    res = '0;
    unique case (op)
      OP_ENQUEUE: begin
        if (held == DEPTH_CNT) begin
          res.status = ST_FULL;
        end else begin
          ring_words[tail_idx] = val;
          tail_idx = advance(tail_idx);
          held = held + CNT_W'(1);
        end
      end
      OP_DEQUEUE: begin
        if (held == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value_out = ring_words[head_idx];
          head_idx = advance(head_idx);
          held = held - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (held == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value_out = ring_words[head_idx];
        end
      end
      OP_SEARCH: begin
        res.status = ST_NOT_FOUND;
        idx = head_idx;
        for (int k = 0; k < int'(held); k++) begin
          if (res.status == ST_NOT_FOUND && ring_words[idx] == val) begin
            res.position = CNT_W'(k + 1);
            res.status = ST_OK;
          end
          idx = advance(idx);
        end
      end
      OP_CLEAR: begin
        head_idx = '0;
        tail_idx = '0;
        held = '0;
      end
      default: begin
      end
    endcase
    res.entry_count = held;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head_idx = '0;
      tail_idx = '0;
      held = '0;
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("result with no request waiting: tdata %h tuser %h",
                                 out_tdata, out_tuser));
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[31:0] !== want.value_out) begin
            log_mismatch($sformatf("value_out got %h want %h", out_tdata[31:0],
                                   want.value_out));
          end
          if (out_tdata[36:32] !== want.position) begin
            log_mismatch($sformatf("position got %0d want %0d", out_tdata[36:32],
                                   want.position));
          end
          if (out_tdata[41:37] !== want.entry_count) begin
            log_mismatch($sformatf("entry_count got %0d want %0d", out_tdata[41:37],
                                   want.entry_count));
          end
          if (out_tdata[47:42] !== '0) begin
            log_mismatch($sformatf("padding bits got %h want 0", out_tdata[47:42]));
          end
          if (out_tuser !== want.status) begin
            log_mismatch($sformatf("status got %0d want %0d", out_tuser, want.status));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_queue_op(in_tuser, in_tdata));
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fqws_pkg::*;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  int          mismatches;
  int          outstanding;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  logic [31:0] recent_values [$];

  fifo_queue_with_search dut (.*);

  queue_result_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(4_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 4) return 32'($urandom_range(0, 7));
    if (sel == 4) return 32'h8000_0000;
    if (sel == 5) return 32'h7fff_ffff;
    if (sel == 6) return 32'hffff_ffff;
    return $urandom();
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [31:0] val);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= val;
    do @(posedge clk); while (!in_tready);
    if (op == OP_ENQUEUE) begin
      recent_values.push_back(val);
      if (recent_values.size() > 24) void'(recent_values.pop_front());
    end
  endtask

  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int sent;
    int phase_len;
    int roll;
    int enq_share;
    int deq_share;
    int guard;
    mix_t mix;
    logic [2:0] op;
    logic [31:0] val;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_DEQUEUE, $urandom());
    send_request(OP_PEEK, $urandom());
    send_request(OP_SEARCH, 32'h0);
    send_request(OP_ENQUEUE, 32'h8000_0000);
    send_request(OP_ENQUEUE, 32'h7fff_ffff);
    send_request(OP_ENQUEUE, 32'h0);
    send_request(OP_ENQUEUE, 32'h7fff_ffff);
    send_request(OP_PEEK, $urandom());
    send_request(OP_SEARCH, 32'h7fff_ffff);
    send_request(OP_SEARCH, 32'h0);
    send_request(OP_SEARCH, 32'hffff_ffff);
    send_request(OP_DEQUEUE, $urandom());
    send_request(OP_SEARCH, 32'h7fff_ffff);
    send_request(3'd5, $urandom());
    send_request(3'd6, $urandom());
    send_request(3'd7, $urandom());
    send_request(OP_CLEAR, $urandom());
    send_request(OP_PEEK, $urandom());
    send_request(OP_SEARCH, 32'h7fff_ffff);
    send_request(OP_ENQUEUE, 32'hffff_ffff);
    send_request(OP_DEQUEUE, $urandom());
    send_request(OP_DEQUEUE, $urandom());

    sent = 0;
    while (sent < 1200) begin
      mix = (sent == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 60);
      enq_share = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 15 : 35;
      deq_share = (mix == MIX_FILL) ? 12 : (mix == MIX_DRAIN) ? 50 : 30;
      for (int i = 0; i < phase_len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < enq_share) begin
          op = OP_ENQUEUE;
        end else if (roll < enq_share + deq_share) begin
          op = OP_DEQUEUE;
        end else if (roll < 88) begin
          op = OP_SEARCH;
        end else if (roll < 96) begin
          op = OP_PEEK;
        end else if (roll < 97) begin
          op = OP_CLEAR;
        end else begin
          op = 3'($urandom_range(5, 7));
        end
        if (op == OP_SEARCH && recent_values.size() > 0 && $urandom_range(0, 9) < 6) begin
          val = recent_values[$urandom_range(0, recent_values.size() - 1)];
        end else begin
          val = pick_value();
        end
        send_request(op, val);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### fifo_queue_with_search.f
sv/fqws_pkg.sv
sv/fqws_ram.sv
sv/fqws_seq.sv
sv/fifo_queue_with_search.sv
tb/sv/queue_result_checker.sv
tb/sv/tb_top.sv
